[sv/bdpc_pkg.sv]
// Package for the button debounce and press classifier.
// Holds the shared widths, register indexes, reset values and beat types.
// No dependencies.
package bdpc_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD        = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET    = 16'd15;
    localparam logic [CFG_W-1:0] SHORT_LIMIT_RESET = 16'd500;
    localparam logic [CFG_W-1:0] HOLD_RESET        = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] short_limit_ms;
        logic [CFG_W-1:0] hold_ms;
    } cfg_t;

    typedef struct packed {
        logic press_event;
        logic release_event;
        logic short_event;
        logic hold_event;
        logic stable_level;
    } result_t;

endpackage

[sv/bdpc_if.sv]
// Channel interfaces for the button debounce and press classifier.
// bdpc_poll_if carries one poll beat, bdpc_result_if one result beat.
// No dependencies.
interface bdpc_poll_if;
    logic        valid;
    logic        ready;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdpc_result_if;
    logic valid;
    logic ready;
    logic press_event;
    logic release_event;
    logic short_event;
    logic hold_event;
    logic stable_level;

    modport source (output valid, output press_event, output release_event,
                    output short_event, output hold_event, output stable_level,
                    input ready);
    modport sink   (input valid, input press_event, input release_event,
                    input short_event, input hold_event, input stable_level,
                    output ready);
endinterface

[sv/bdpc_core.sv]
// Debounce and press classification state for the button classifier.
// Updates state on each accepted poll and produces that poll's result.
// Depends on bdpc_pkg.
module bdpc_core
    import bdpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              pin_level,
    input  logic [TIME_W-1:0] now_ms,
    input  cfg_t              cfg,
    output result_t           res
);

    logic              raw_seen_reg, raw_seen_next;
    logic              settling_reg, settling_next;
    logic [TIME_W-1:0] settle_start_reg, settle_start_next;
    logic              debounced_reg, debounced_next;
    logic              hold_armed_reg, hold_armed_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;

    logic              raw_change;
    logic              settling_mid;
    logic [TIME_W-1:0] settle_el;
    logic              settle_done;
    logic              rise;
    logic              fall;
    logic [TIME_W-1:0] press_el;
    logic [TIME_W-1:0] hold_el;
    logic              armed_mid;
    logic              hold_hit;

    // Raw level tracking; a change restarts the settle timer (elapsed zero)
    always_comb
    begin
        raw_change        = pin_level != raw_seen_reg;
        raw_seen_next     = pin_level;
        settle_start_next = raw_change ? now_ms : settle_start_reg;
        settling_mid      = raw_change | settling_reg;
        settle_el         = raw_change ? '0 : (now_ms - settle_start_reg);
        settle_done       = settling_mid && (settle_el >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms});
        settling_next     = settling_mid & ~settle_done;
        debounced_next    = settle_done ? raw_seen_next : debounced_reg;
    end

    // Press / release edges and hold detection
    always_comb
    begin
        rise             = debounced_next & ~debounced_reg;
        fall             = ~debounced_next & debounced_reg;
        press_el         = now_ms - press_start_reg;
        press_start_next = rise ? now_ms : press_start_reg;
        hold_el          = rise ? '0 : press_el;
        priority if (rise)
            armed_mid = 1'b1;
        else if (fall)
            armed_mid = 1'b0;
        else
            armed_mid = hold_armed_reg;
        hold_hit        = armed_mid && (hold_el >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_ms});
        hold_armed_next = armed_mid & ~hold_hit;

        res.press_event   = rise;
        res.release_event = fall;
        res.short_event   = fall && (press_el <= {{(TIME_W-CFG_W){1'b0}}, cfg.short_limit_ms});
        res.hold_event    = hold_hit;
        res.stable_level  = debounced_next;
    end

    // State registers, updated once per accepted poll beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_seen_reg     <= 1'b0;
            settling_reg     <= 1'b0;
            settle_start_reg <= '0;
            debounced_reg    <= 1'b0;
            hold_armed_reg   <= 1'b0;
            press_start_reg  <= '0;
        end
        else if (step)
        begin
            raw_seen_reg     <= raw_seen_next;
            settling_reg     <= settling_next;
            settle_start_reg <= settle_start_next;
            debounced_reg    <= debounced_next;
            hold_armed_reg   <= hold_armed_next;
            press_start_reg  <= press_start_next;
        end
    end

endmodule

[sv/bdpc_out_buf.sv]
// Result output register with one skid entry for the button classifier.
// Keeps polls flowing while a result beat waits on the sink.
// Depends on bdpc_pkg.
module bdpc_out_buf
    import bdpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    // Main register refills from skid first, then from a new beat
    always_comb
    begin
        pop             = out_valid_reg & out_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
            out_valid_next = 1'b0;
        if (skid_valid_reg && (pop || !out_valid_reg))
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else if (push && (pop || !out_valid_reg))
        begin
            out_valid_next = 1'b1;
            out_data_next  = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign space     = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[sv/button_debounce_press_classifier.sv]
// Button debounce and press classifier, top level.
// Each result beat is registered in the output buffer: the main register, or the skid entry while the sink stalls.
// Throughput: one poll per cycle while the output buffer has space; the skid entry in the output buffer
// holds one result beat while the sink stalls, and the poll side drops ready while that entry is full.
// Reset (rst_n low, async): state cleared, registers to 15 / 500 / 1000 ms.
// Depends on bdpc_pkg, bdpc_if, bdpc_core, bdpc_out_buf.
module button_debounce_press_classifier
    import bdpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    bdpc_poll_if.sink            poll,
    bdpc_result_if.source        result
);

    cfg_t    cfg_reg;
    logic    poll_beat;
    logic    space;
    result_t core_res;
    result_t out_res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms    <= DEBOUNCE_RESET;
            cfg_reg.short_limit_ms <= SHORT_LIMIT_RESET;
            cfg_reg.hold_ms        <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:    cfg_reg.debounce_ms    <= cfg_data;
                CFG_SHORT_LIMIT: cfg_reg.short_limit_ms <= cfg_data;
                CFG_HOLD:        cfg_reg.hold_ms        <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign poll.ready = space;
    assign poll_beat  = poll.valid & space;

    bdpc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (poll_beat),
        .pin_level (poll.pin_level),
        .now_ms    (poll.now_ms),
        .cfg       (cfg_reg),
        .res       (core_res)
    );

    bdpc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (poll_beat),
        .push_data (core_res),
        .space     (space),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_res)
    );

    assign result.press_event   = out_res.press_event;
    assign result.release_event = out_res.release_event;
    assign result.short_event   = out_res.short_event;
    assign result.hold_event    = out_res.hold_event;
    assign result.stable_level  = out_res.stable_level;

endmodule
